// File: rtl/cdf2d_pkg.sv
// ----------------------------------------------------------------------------
// cdf2d_pkg
// Types, step codes and saturation helpers for the 2D smooth-damp follower.
// ----------------------------------------------------------------------------
package cdf2d_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_WB
    } t_state;

    typedef logic [4:0] t_pc;

    localparam t_pc PC_OMEGA  = 5'd0;
    localparam t_pc PC_X      = 5'd1;
    localparam t_pc PC_X2     = 5'd2;
    localparam t_pc PC_X3     = 5'd3;
    localparam t_pc PC_T1     = 5'd4;
    localparam t_pc PC_T2     = 5'd5;
    localparam t_pc PC_E      = 5'd6;
    localparam t_pc PC_MAXC   = 5'd7;
    localparam t_pc PC_SQX    = 5'd8;
    localparam t_pc PC_SQY    = 5'd9;
    localparam t_pc PC_SQRT   = 5'd10;
    localparam t_pc PC_LIMIT  = 5'd11;
    localparam t_pc PC_R      = 5'd12;
    localparam t_pc PC_SCX    = 5'd13;
    localparam t_pc PC_SCY    = 5'd14;
    localparam t_pc PC_W      = 5'd15;
    localparam t_pc PC_TX     = 5'd16;
    localparam t_pc PC_TW     = 5'd17;
    localparam t_pc PC_NV     = 5'd18;
    localparam t_pc PC_M3     = 5'd19;
    localparam t_pc PC_P1     = 5'd20;
    localparam t_pc PC_P2     = 5'd21;
    localparam t_pc PC_DECIDE = 5'd22;

    localparam logic [0:0]  REG_SMOOTH_TIME = 1'b0;
    localparam logic [0:0]  REG_MAX_SPEED   = 1'b1;

    localparam logic [23:0] ST_RESET   = 24'd19661;
    localparam logic [31:0] MS_RESET   = 32'hFFFF_FFFF;
    localparam logic [23:0] ST_MIN     = 24'd7;
    localparam logic [47:0] C_048      = 48'd31457;
    localparam logic [47:0] C_0235     = 48'd15401;
    localparam logic [24:0] X_CAP      = 25'h100_0000;
    localparam logic [46:0] INT_BIG    = {47{1'b1}};
    localparam logic signed [49:0] BIG_P = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] BIG_N = -50'sh0_7FFF_FFFF_FFFF;

    // product magnitude shifted right, saturated to the big bound
    function automatic logic [46:0] mulsh_mag(input logic [95:0] p, input int sh);
        logic [63:0] lo;
        lo = p[63:0] >> sh;
        if (p[95:64] != 32'd0 || lo > {17'd0, INT_BIG}) begin
            return INT_BIG;
        end
        return lo[46:0];
    endfunction

    function automatic logic signed [49:0] with_sign(input logic [46:0] m, input logic neg);
        logic signed [49:0] v;
        v = $signed({3'b000, m});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [49:0] sat_big(input logic signed [49:0] a);
        if (a > BIG_P) begin
            return BIG_P;
        end
        if (a < BIG_N) begin
            return BIG_N;
        end
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] a);
        if (a > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (a < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return a[31:0];
    endfunction

    function automatic logic [47:0] mag50(input logic signed [49:0] a);
        logic signed [49:0] m;
        m = (a < 0) ? -a : a;
        return m[47:0];
    endfunction

endpackage

// File: rtl/critically_damped_follower_2d_unit.sv
// ----------------------------------------------------------------------------
// critically_damped_follower_2d_unit
// Critically damped spring follower (smooth damp) in Q16.16, one shared
// multiplier, restoring divider and square root under a step sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        cur x,y  target x,y  delta_time
// m_axis    out  m_axis_tvalid/tready        next x,y
// apb       in   psel/penable/pwrite/pready  smooth_time @0, max_speed @4
//
// An item's run time is set by the bit-serial divider (34, 49 and 63 steps)
// and the 32-step square root; the third division runs only when the speed limit applies.
// The multiplier works through its second operand in 16-bit digits.
// Reset is synchronous, clears velocity and restores the register defaults.
// A result waits in the output register; the next item is taken meanwhile and
// only its final step stalls while the previous result is not yet taken.
// ----------------------------------------------------------------------------
module critically_damped_follower_2d_unit
    import cdf2d_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // current_x, current_y, target_x, target_y, delta_time
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_x, next_y
    output logic [63:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;
    logic   r_axis, n_axis;

    logic [23:0] r_st;
    logic [31:0] r_ms;

    logic signed [31:0] r_cur [2];
    logic signed [31:0] r_tgt [2];
    logic signed [31:0] r_vel [2];
    logic signed [33:0] r_c   [2];
    logic signed [31:0] r_o   [2];
    logic signed [49:0] r_nv  [2];
    logic [15:0]        r_dt;

    logic [30:0] r_omega;
    logic [24:0] r_x;
    logic [32:0] r_x2;
    logic [40:0] r_x3;
    logic [39:0] r_den;
    logic [32:0] r_e;
    logic [39:0] r_maxc;
    logic [63:0] r_sq;
    logic [32:0] r_len;
    logic [29:0] r_r;
    logic signed [49:0] r_a;
    logic signed [49:0] r_t;
    logic [63:0] r_p1, r_p2;

    logic [47:0] r_ma, r_mb;
    logic [95:0] r_mp;
    logic [1:0]  r_mcnt;
    logic [63:0] mul_pp;

    logic [63:0] r_dnum, r_dq;
    logic [39:0] r_drem, r_dd;
    logic [5:0]  r_dcnt;

    logic [63:0] r_sv, r_sres;
    logic [4:0]  r_scnt;

    logic        r_ovalid;
    logic [63:0] r_odata;

    logic [23:0] st_eff;
    logic        in_acc, out_take, dec_go, over;
    logic [40:0] rem_sh;
    logic [63:0] sbit;
    logic [64:0] stry;
    logic signed [32:0] d1 [2];
    logic signed [32:0] d2 [2];
    logic signed [49:0] base;
    logic        n1, n2;

    assign st_eff        = (r_st < ST_MIN) ? ST_MIN : r_st;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_ovalid && m_axis_tready;
    assign dec_go        = (r_state == ST_EXEC) && (r_pc == PC_DECIDE)
                           && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_MAX_SPEED) ? r_ms : {8'd0, r_st};

    assign mul_pp = 64'(r_ma) * 64'(r_mb[47:32]);
    assign rem_sh = {r_drem, r_dnum[63]};
    assign sbit   = 64'd1 << {r_scnt, 1'b0};
    assign stry   = {1'b0, r_sres} + {1'b0, sbit};
    assign base   = 50'(r_cur[r_axis]) - 50'(r_c[r_axis]);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            d1[k] = 33'(r_tgt[k]) - 33'(r_cur[k]);
            d2[k] = 33'(r_o[k]) - 33'(r_tgt[k]);
        end
        n1 = d1[0][32] ^ d2[0][32];
        n2 = d1[1][32] ^ d2[1][32];
        if (!n1 && !n2) begin
            over = (r_p1 != 64'd0) || (r_p2 != 64'd0);
        end else if (n1 && n2) begin
            over = 1'b0;
        end else if (n1) begin
            over = r_p2 > r_p1;
        end else begin
            over = r_p1 > r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= PC_OMEGA;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_axis  = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                    n_pc    = PC_OMEGA;
                    n_axis  = 1'b0;
                end
            end
            ST_EXEC: begin
                case (r_pc)
                    PC_LIMIT:  n_pc = ({7'd0, r_len} > r_maxc) ? PC_R : PC_W;
                    PC_DECIDE: if (dec_go) n_state = ST_IDLE;
                    PC_OMEGA, PC_E, PC_R: n_state = ST_DIV;
                    PC_SQRT:   n_state = ST_SQRT;
                    default:   n_state = ST_MUL;
                endcase
            end
            ST_MUL:  if (r_mcnt == 2'd2) n_state = ST_WB;
            ST_DIV:  if (r_dcnt == 6'd0) n_state = ST_WB;
            ST_SQRT: if (r_scnt == 5'd0) n_state = ST_WB;
            ST_WB: begin
                n_state = ST_EXEC;
                if (r_pc == PC_M3 && !r_axis) begin
                    n_pc   = PC_W;
                    n_axis = 1'b1;
                end else begin
                    n_pc = r_pc + 5'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration, velocity and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_RESET;
            r_ms     <= MS_RESET;
            r_vel[0] <= '0;
            r_vel[1] <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_SMOOTH_TIME) r_st <= pwdata[23:0];
                else                             r_ms <= pwdata;
            end
            if (out_take) r_ovalid <= 1'b0;
            if (dec_go) begin
                r_ovalid <= 1'b1;
                if (over) begin
                    r_vel[0] <= '0;
                    r_vel[1] <= '0;
                end else begin
                    r_vel[0] <= sat32(r_nv[0]);
                    r_vel[1] <= sat32(r_nv[1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_go) begin
            r_odata <= over ? {r_tgt[1], r_tgt[0]} : {r_o[1], r_o[0]};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_cur[0] <= s_axis_tdata[31:0];
                    r_cur[1] <= s_axis_tdata[63:32];
                    r_tgt[0] <= s_axis_tdata[95:64];
                    r_tgt[1] <= s_axis_tdata[127:96];
                    r_dt     <= s_axis_tdata[143:128];
                    r_c[0]   <= 34'($signed(s_axis_tdata[31:0]))
                              - 34'($signed(s_axis_tdata[95:64]));
                    r_c[1]   <= 34'($signed(s_axis_tdata[63:32]))
                              - 34'($signed(s_axis_tdata[127:96]));
                end
            end
            ST_EXEC: begin
                r_mp   <= '0;
                r_mcnt <= '0;
                r_drem <= '0;
                r_dq   <= '0;
                case (r_pc)
                    PC_OMEGA: begin
                        r_dnum <= 64'h8000_0000_0000_0000;
                        r_dd   <= {16'd0, st_eff};
                        r_dcnt <= 6'd33;
                    end
                    PC_E: begin
                        r_dnum <= 64'h8000_0000_0000_0000;
                        r_dd   <= r_den;
                        r_dcnt <= 6'd48;
                    end
                    PC_R: begin
                        r_dnum <= {r_maxc[32:0], 31'd0};
                        r_dd   <= {7'd0, r_len};
                        r_dcnt <= 6'd62;
                    end
                    PC_SQRT: begin
                        r_sv   <= r_sq;
                        r_sres <= '0;
                        r_scnt <= 5'd31;
                    end
                    PC_X:    begin r_ma <= {17'd0, r_omega}; r_mb <= {32'd0, r_dt}; end
                    PC_X2:   begin r_ma <= {23'd0, r_x};     r_mb <= {23'd0, r_x}; end
                    PC_X3:   begin r_ma <= {15'd0, r_x2};    r_mb <= {23'd0, r_x}; end
                    PC_T1:   begin r_ma <= C_048;            r_mb <= {15'd0, r_x2}; end
                    PC_T2:   begin r_ma <= C_0235;           r_mb <= {7'd0, r_x3}; end
                    PC_MAXC: begin r_ma <= {16'd0, r_ms};    r_mb <= {24'd0, st_eff}; end
                    PC_SQX: begin
                        r_ma <= mag50(50'(r_c[0]));
                        r_mb <= mag50(50'(r_c[0]));
                    end
                    PC_SQY: begin
                        r_ma <= mag50(50'(r_c[1]));
                        r_mb <= mag50(50'(r_c[1]));
                    end
                    PC_SCX:  begin r_ma <= mag50(50'(r_c[0])); r_mb <= {18'd0, r_r}; end
                    PC_SCY:  begin r_ma <= mag50(50'(r_c[1])); r_mb <= {18'd0, r_r}; end
                    PC_W: begin
                        r_ma <= {17'd0, r_omega};
                        r_mb <= mag50(50'(r_c[r_axis]));
                    end
                    PC_TX:   begin r_ma <= mag50(r_a); r_mb <= {32'd0, r_dt}; end
                    PC_TW:   begin r_ma <= {17'd0, r_omega}; r_mb <= mag50(r_t); end
                    PC_NV, PC_M3: begin r_ma <= mag50(r_a); r_mb <= {15'd0, r_e}; end
                    PC_P1: begin
                        r_ma <= mag50(50'(d1[0]));
                        r_mb <= mag50(50'(d2[0]));
                    end
                    PC_P2: begin
                        r_ma <= mag50(50'(d1[1]));
                        r_mb <= mag50(50'(d2[1]));
                    end
                    default: ;
                endcase
            end
            ST_MUL: begin
                r_mp   <= {r_mp[79:0], 16'd0} + {32'd0, mul_pp};
                r_mb   <= {r_mb[31:0], 16'd0};
                r_mcnt <= r_mcnt + 2'd1;
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_dd}) begin
                    r_drem <= 40'(rem_sh - {1'b0, r_dd});
                    r_dq   <= {r_dq[62:0], 1'b1};
                end else begin
                    r_drem <= rem_sh[39:0];
                    r_dq   <= {r_dq[62:0], 1'b0};
                end
                r_dnum <= {r_dnum[62:0], 1'b0};
                r_dcnt <= r_dcnt - 6'd1;
            end
            ST_SQRT: begin
                if ({1'b0, r_sv} >= stry) begin
                    r_sv   <= r_sv - stry[63:0];
                    r_sres <= {1'b0, r_sres[63:1]} + sbit;
                end else begin
                    r_sres <= {1'b0, r_sres[63:1]};
                end
                r_scnt <= r_scnt - 5'd1;
            end
            ST_WB: begin
                case (r_pc)
                    PC_OMEGA: r_omega <= r_dq[30:0];
                    PC_X:     r_x <= (r_mp[47:16] > {7'd0, X_CAP}) ? X_CAP : r_mp[40:16];
                    PC_X2:    r_x2 <= r_mp[48:16];
                    PC_X3:    r_x3 <= r_mp[56:16];
                    PC_T1:    r_den <= 40'd65536 + {15'd0, r_x} + r_mp[55:16];
                    PC_T2:    r_den <= r_den + r_mp[55:16];
                    PC_E:     r_e <= r_dq[32:0];
                    PC_MAXC:  r_maxc <= r_mp[55:16];
                    PC_SQX:   r_sq <= r_mp[65:2];
                    PC_SQY:   r_sq <= r_sq + r_mp[65:2];
                    PC_SQRT:  r_len <= {r_sres[31:0], 1'b0};
                    PC_R:     r_r <= r_dq[29:0];
                    PC_SCX: begin
                        r_c[0] <= r_c[0][33] ? -$signed({1'b0, r_mp[62:30]})
                                             : $signed({1'b0, r_mp[62:30]});
                    end
                    PC_SCY: begin
                        r_c[1] <= r_c[1][33] ? -$signed({1'b0, r_mp[62:30]})
                                             : $signed({1'b0, r_mp[62:30]});
                    end
                    PC_W: begin
                        r_a <= sat_big(50'(r_vel[r_axis])
                               + with_sign(mulsh_mag(r_mp, 16), r_c[r_axis][33]));
                    end
                    PC_TX: r_t <= with_sign(mulsh_mag(r_mp, 16), r_a[49]);
                    PC_TW: begin
                        r_a <= sat_big(50'(r_vel[r_axis])
                               - with_sign(mulsh_mag(r_mp, 16), r_t[49]));
                    end
                    PC_NV: begin
                        r_nv[r_axis] <= with_sign(mulsh_mag(r_mp, 32), r_a[49]);
                        r_a          <= sat_big(50'(r_c[r_axis]) + r_t);
                    end
                    PC_M3: begin
                        r_o[r_axis] <= sat32(sat_big(base
                                       + with_sign(mulsh_mag(r_mp, 32), r_a[49])));
                    end
                    PC_P1: r_p1 <= r_mp[63:0];
                    PC_P2: r_p2 <= r_mp[63:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/cdf2d_checker.sv
// ----------------------------------------------------------------------------
// cdf2d_checker
// Port-level checks for the smooth-damp follower, bound to the top level.
// ----------------------------------------------------------------------------
module cdf2d_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !(m_axis_tvalid && !$past(m_axis_tvalid)))
        else $error("result appeared too early");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("config access stalled");

endmodule

bind critically_damped_follower_2d_unit cdf2d_checker u_cdf2d_checker (.*);
